// ----- sv/wdpf_pkg.sv -----
// Shared constants, register codes and types for the wall distance position filter.
package wdpf_pkg;

  localparam int POS_FRAC_BITS_DEF = 8;

  localparam int MM_W  = 14;
  localparam int POS_W = 16;
  localparam int UNC_W = 16;
  localparam int K_W   = 16;

  localparam logic [MM_W-1:0] MM_LOW  = 14'd20;
  localparam logic [MM_W-1:0] MM_HIGH = 14'd2000;

  localparam logic [UNC_W-1:0] UNC_ONE = 16'd16384;

  localparam logic [15:0] DEF_SENSOR_NOISE  = 16'd8192;
  localparam logic [15:0] DEF_PROCESS_NOISE = 16'd1638;
  localparam logic [15:0] DEF_FIELD_SIZE    = 16'd35968;

  // shared divider geometry
  localparam int DIV_W     = 32;
  localparam int DEN_W     = 17;
  localparam int DIV_STEPS = DIV_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // mm to inches: (mm*10 << frac + 127) / 254 == (mm*5 << frac + 63) / 127;
  // the divide by 127 is a multiply by ceil(2^33/127), exact below 2^26
  localparam int                  MM_RCP_W     = 27;
  localparam logic [MM_RCP_W-1:0] MM_RCP       = 27'd67637281;
  localparam int                  MM_RCP_SHIFT = 33;
  localparam int                  MM_ROUND     = 63;

  // APB register map, word addressed
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_SENSOR_NOISE  = 2'd0;
  localparam logic [1:0] REG_PROCESS_NOISE = 2'd1;
  localparam logic [1:0] REG_FIELD_SIZE    = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

endpackage

// ----- sv/wdpf_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
module wdpf_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  wdpf_pkg::div_req_t           req,
  output logic                         done,
  output logic [wdpf_pkg::DIV_W-1:0]   quotient
);

  localparam int DIV_W = wdpf_pkg::DIV_W;
  localparam int DEN_W = wdpf_pkg::DEN_W;
  localparam int CNT_W = wdpf_pkg::CNT_W;

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DEN_W-1:0] dsr_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_nxt;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dsr_r};
  assign trial   = shifted - {1'b0, dsr_r};
  assign rem_nxt = ge ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && !req.start && (cnt_r == CNT_W'(1));
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(wdpf_pkg::DIV_STEPS);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1))
          run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- sv/wdpf_mul.sv -----
// Registered unsigned multiplier shared by the position and confidence updates.
module wdpf_mul #(
  parameter int A_W = 21,
  parameter int B_W = 17
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  localparam int P_W = A_W + B_W;

  logic [P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= P_W'(a) * P_W'(b);
  end

  assign p = p_r;

endmodule

// ----- sv/wall_distance_position_filter.sv -----
// Top level: register port, step sequencer and per-axis filter state.
//
// Two-axis scalar Kalman position filter fed by four wall distance sensors.
// An item carries front, back, left and right distances in mm; a reading
// counts only when 20 < mm < 2000. Y uses front (mirrored against
// field_size) or else back; X uses left or else right (mirrored). Each used
// axis converts mm to inches with a constant reciprocal multiply, computes
// the gain conf/(conf+sensor_noise) on the shared bit-per-cycle divider and
// runs two passes through the registered multiplier. in_stall is high from
// the accept until the result item is registered, and longer while the
// previous result item is still stalled. One result item follows each input
// item; it waits in the output register while the next item is taken.
// Registers (APB, word addressed): 0 sensor_noise, 1 process_noise,
// 2 field_size.
module wall_distance_position_filter #(
  parameter int POS_FRAC_BITS = wdpf_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wdpf_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wdpf_pkg::MM_W-1:0]     in_front_mm,
  input  logic [wdpf_pkg::MM_W-1:0]     in_back_mm,
  input  logic [wdpf_pkg::MM_W-1:0]     in_left_mm,
  input  logic [wdpf_pkg::MM_W-1:0]     in_right_mm,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wdpf_pkg::POS_W-1:0]    out_pos_x,
  output logic [wdpf_pkg::POS_W-1:0]    out_pos_y,
  output logic [wdpf_pkg::UNC_W-1:0]    out_conf_x_out,
  output logic [wdpf_pkg::UNC_W-1:0]    out_conf_y_out,
  output logic                          out_x_updated,
  output logic                          out_y_updated
);

  localparam int MM_W   = wdpf_pkg::MM_W;
  localparam int POS_W  = wdpf_pkg::POS_W;
  localparam int UNC_W  = wdpf_pkg::UNC_W;
  localparam int K_W    = wdpf_pkg::K_W;
  localparam int DIV_W  = wdpf_pkg::DIV_W;
  localparam int DEN_W  = wdpf_pkg::DEN_W;

  // usable mm < 2000 gives mm*10 < 2^15, so meas < 2^(frac+8)
  localparam int MEAS_W = POS_FRAC_BITS + 8;
  localparam int VAL_W  = (MEAS_W > POS_W) ? MEAS_W : POS_W;
  localparam int DIFF_W = VAL_W + 2;
  localparam int MAG_W  = VAL_W + 1;
  localparam int EST_W  = MAG_W + 2;
  localparam int MB_W   = K_W + 1;
  localparam int PROD_W = MAG_W + MB_W;
  // usable mm*5 < 2^14
  localparam int MMX_W  = MM_W + POS_FRAC_BITS;
  localparam int RCP_W  = MMX_W + wdpf_pkg::MM_RCP_W;

  localparam logic AXIS_Y = 1'b0;
  localparam logic AXIS_X = 1'b1;

  localparam logic [MB_W-1:0]   K_ONE    = MB_W'(1) << K_W;
  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (K_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_AXIS, S_MMW, S_MEAS, S_GAIN, S_GAINW, S_MUL1, S_MUL2, S_MUL3, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0] sensor_noise_r;
  logic [15:0] process_noise_r;
  logic [15:0] field_size_r;

  // filter state
  logic [POS_W-1:0] est_x_r, est_y_r;
  logic [UNC_W-1:0] unc_x_r, unc_y_r;

  // per-item working registers
  logic            axis_r;
  logic            x_use_r, y_use_r;
  logic            x_mir_r, y_mir_r;
  logic [MM_W-1:0] x_mm_r, y_mm_r;
  logic [UNC_W-1:0] conf_r;
  logic [K_W-1:0]   k_r;
  logic [MAG_W-1:0] mag_r;
  logic             neg_r;
  logic [MMX_W-1:0] mmx_r;
  logic [RCP_W-1:0] rcp_r;

  // result register
  logic             out_valid_r;
  logic [POS_W-1:0] out_pos_x_r, out_pos_y_r;
  logic [UNC_W-1:0] out_conf_x_r, out_conf_y_r;
  logic             out_xu_r, out_yu_r;

  function automatic logic usable(input logic [MM_W-1:0] mm);
    return (mm > wdpf_pkg::MM_LOW) && (mm < wdpf_pkg::MM_HIGH);
  endfunction

  // ---------------------------------------------------------------
  // APB
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      wdpf_pkg::REG_SENSOR_NOISE:  prdata = 32'(sensor_noise_r);
      wdpf_pkg::REG_PROCESS_NOISE: prdata = 32'(process_noise_r);
      wdpf_pkg::REG_FIELD_SIZE:    prdata = 32'(field_size_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_noise_r  <= wdpf_pkg::DEF_SENSOR_NOISE;
      process_noise_r <= wdpf_pkg::DEF_PROCESS_NOISE;
      field_size_r    <= wdpf_pkg::DEF_FIELD_SIZE;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        wdpf_pkg::REG_SENSOR_NOISE:  sensor_noise_r  <= pwdata[15:0];
        wdpf_pkg::REG_PROCESS_NOISE: process_noise_r <= pwdata[15:0];
        wdpf_pkg::REG_FIELD_SIZE:    field_size_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // current axis selection
  logic             use_cur, mir_cur;
  logic [MM_W-1:0]  mm_cur;
  logic [POS_W-1:0] est_cur;
  logic [UNC_W-1:0] unc_cur;

  assign use_cur = (axis_r == AXIS_X) ? x_use_r : y_use_r;
  assign mir_cur = (axis_r == AXIS_X) ? x_mir_r : y_mir_r;
  assign mm_cur  = (axis_r == AXIS_X) ? x_mm_r  : y_mm_r;
  assign est_cur = (axis_r == AXIS_X) ? est_x_r : est_y_r;
  assign unc_cur = (axis_r == AXIS_X) ? unc_x_r : unc_y_r;

  // confidence growth, saturating
  logic [UNC_W:0]   conf_sum;
  logic [UNC_W-1:0] conf_nxt;
  assign conf_sum = (UNC_W + 1)'(unc_cur) + (UNC_W + 1)'(process_noise_r);
  assign conf_nxt = conf_sum[UNC_W] ? {UNC_W{1'b1}} : conf_sum[UNC_W-1:0];

  logic [DEN_W-1:0] den;
  assign den = DEN_W'(conf_r) + DEN_W'(sensor_noise_r);

  // mm * 5 as shift-add; wraps only for readings that are never used
  logic [MM_W-1:0]  mm5;
  logic [MMX_W-1:0] mmx;
  assign mm5 = MM_W'({mm_cur, 2'b00}) + mm_cur;
  assign mmx = (MMX_W'(mm5) << POS_FRAC_BITS) + MMX_W'(wdpf_pkg::MM_ROUND);

  // ---------------------------------------------------------------
  // shared divider, used for the gain
  wdpf_pkg::div_req_t div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;

  always_comb begin
    div_req.start    = (state_r == S_GAIN);
    div_req.dividend = {conf_r, {K_W{1'b0}}};
    div_req.divisor  = den;
  end

  wdpf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // measurement and error against the estimate
  logic [MEAS_W-1:0]        meas_u;
  logic signed [DIFF_W-1:0] meas_s;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;

  assign meas_u   = rcp_r[wdpf_pkg::MM_RCP_SHIFT +: MEAS_W];
  assign meas_s   = mir_cur ? ($signed(DIFF_W'(field_size_r)) - $signed(DIFF_W'(meas_u)))
                            : $signed(DIFF_W'(meas_u));
  assign diff     = meas_s - $signed(DIFF_W'(est_cur));
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // gain, saturated; zero denominator gives zero gain
  logic [K_W-1:0] k_nxt;
  always_comb begin
    if (den == '0)
      k_nxt = '0;
    else if (div_q[DIV_W-1:K_W] != '0)
      k_nxt = {K_W{1'b1}};
    else
      k_nxt = div_q[K_W-1:0];
  end

  // ---------------------------------------------------------------
  // shared multiplier
  logic [MAG_W-1:0]  mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = mag_r;
      mul_b = MB_W'(k_r);
    end else begin
      mul_a = MAG_W'(conf_r);
      mul_b = K_ONE - MB_W'(k_r);
    end
  end

  wdpf_mul #(
    .A_W (MAG_W),
    .B_W (MB_W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  logic [PROD_W-1:0]       prod_rnd;
  logic [MAG_W-1:0]        corr;
  logic signed [EST_W-1:0] est_sum;
  logic [POS_W-1:0]        est_nxt;
  logic [UNC_W-1:0]        unc_nxt;

  assign prod_rnd = mul_p + HALF_LSB;
  assign corr     = prod_rnd[K_W +: MAG_W];
  assign est_sum  = neg_r ? ($signed(EST_W'(est_cur)) - $signed(EST_W'(corr)))
                          : ($signed(EST_W'(est_cur)) + $signed(EST_W'(corr)));
  assign unc_nxt  = prod_rnd[K_W +: UNC_W];

  always_comb begin
    if (est_sum < 0)
      est_nxt = '0;
    else if (est_sum > $signed(EST_W'({POS_W{1'b1}})))
      est_nxt = {POS_W{1'b1}};
    else
      est_nxt = est_sum[POS_W-1:0];
  end

  // ---------------------------------------------------------------
  // sequencer
  logic in_acc;
  logic out_load;
  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= AXIS_Y;
      out_valid_r <= 1'b0;
      est_x_r     <= '0;
      est_y_r     <= '0;
      unc_x_r     <= wdpf_pkg::UNC_ONE;
      unc_y_r     <= wdpf_pkg::UNC_ONE;
      x_use_r     <= 1'b0;
      y_use_r     <= 1'b0;
    end else begin
      if (out_load)
        out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)
        out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            y_use_r <= usable(in_front_mm) || usable(in_back_mm);
            y_mir_r <= usable(in_front_mm);
            y_mm_r  <= usable(in_front_mm) ? in_front_mm : in_back_mm;
            x_use_r <= usable(in_left_mm) || usable(in_right_mm);
            x_mir_r <= !usable(in_left_mm);
            x_mm_r  <= usable(in_left_mm) ? in_left_mm : in_right_mm;
            axis_r  <= AXIS_Y;
            state_r <= S_AXIS;
          end
        end
        S_AXIS: begin
          if (use_cur) begin
            conf_r  <= conf_nxt;
            mmx_r   <= mmx;
            state_r <= S_MMW;
          end else if (axis_r == AXIS_Y) begin
            axis_r <= AXIS_X;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_MMW: begin
          rcp_r   <= RCP_W'(mmx_r) * RCP_W'(wdpf_pkg::MM_RCP);
          state_r <= S_MEAS;
        end
        S_MEAS: begin
          mag_r   <= MAG_W'(diff_abs);
          neg_r   <= diff[DIFF_W-1];
          state_r <= S_GAIN;
        end
        S_GAIN: state_r <= S_GAINW;
        S_GAINW: begin
          if (div_done) begin
            k_r     <= k_nxt;
            state_r <= S_MUL1;
          end
        end
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: begin
          if (axis_r == AXIS_X)
            est_x_r <= est_nxt;
          else
            est_y_r <= est_nxt;
          state_r <= S_MUL3;
        end
        S_MUL3: begin
          if (axis_r == AXIS_X) begin
            unc_x_r <= unc_nxt;
            state_r <= S_OUT;
          end else begin
            unc_y_r <= unc_nxt;
            axis_r  <= AXIS_X;
            state_r <= S_AXIS;
          end
        end
        S_OUT: begin
          // hold here only while the previous result item is still stalled
          if (out_load) begin
            out_pos_x_r  <= est_x_r;
            out_pos_y_r  <= est_y_r;
            out_conf_x_r <= unc_x_r;
            out_conf_y_r <= unc_y_r;
            out_xu_r     <= x_use_r;
            out_yu_r     <= y_use_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_pos_x      = out_pos_x_r;
  assign out_pos_y      = out_pos_y_r;
  assign out_conf_x_out = out_conf_x_r;
  assign out_conf_y_out = out_conf_y_r;
  assign out_x_updated  = out_xu_r;
  assign out_y_updated  = out_yu_r;

endmodule
